[design/segment_fragmentation_scorer_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the segment fragmentation scorer
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_FRAGMENTATION_SCORER_TOP_MACROS_SVH
`define SEGMENT_FRAGMENTATION_SCORER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SFS_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sfs assertion failed");

// The condition must never be true.
`define SFS_ASSERT_NEVER(name, cond) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("sfs assertion failed");

`endif

[design/sfs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Segment fragmentation scorer package
// Transaction types, configuration layout, register codes and constants.
// ----------------------------------------------------------------------------
package sfs_pkg;

	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 8;
	localparam int THR_W       = 7;
	localparam int WEIGHT_W    = 8;
	localparam int FIELD_W     = 16;
	localparam int COUNT_W     = 10;
	localparam int SCORE_W     = 7;
	localparam int COST_W      = 18;
	localparam int PROD_W      = FIELD_W + WEIGHT_W;
	localparam int RECIP_SHIFT = 30;

	localparam logic [SCORE_W-1:0]  SCORE_SCALE = 7'd100;
	localparam logic [PROD_W-1:0]   RECIP_MULT  = 24'd10737418;

	localparam logic [THR_W-1:0]    HIGH_FRAG_THR_RST = 7'd50;
	localparam logic [THR_W-1:0]    BAND_HIGH_THR_RST = 7'd70;
	localparam logic [THR_W-1:0]    BAND_MID_THR_RST  = 7'd40;
	localparam logic [WEIGHT_W-1:0] WEIGHT_HIGH_RST   = 8'd60;
	localparam logic [WEIGHT_W-1:0] WEIGHT_MID_RST    = 8'd80;
	localparam logic [WEIGHT_W-1:0] WEIGHT_LOW_RST    = 8'd110;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HIGH_FRAG_THR = 3'd0,
		CFG_BAND_HIGH_THR = 3'd1,
		CFG_BAND_MID_THR  = 3'd2,
		CFG_WEIGHT_HIGH   = 3'd3,
		CFG_WEIGHT_MID    = 3'd4,
		CFG_WEIGHT_LOW    = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic                block_valid;
		logic                last_block;
		logic [FIELD_W-1:0]  segment_id;
		logic [FIELD_W-1:0]  base_cost;
	} sfs_in_t;

	typedef struct packed {
		logic [FIELD_W-1:0]  result_segment;
		logic [COUNT_W-1:0]  invalid_count;
		logic [COUNT_W-1:0]  run_count;
		logic [SCORE_W-1:0]  score_pct;
		logic                high_frag;
		logic [COST_W-1:0]   weighted_cost;
	} sfs_out_t;

	typedef struct packed {
		logic [THR_W-1:0]    high_frag_threshold;
		logic [THR_W-1:0]    band_high_threshold;
		logic [THR_W-1:0]    band_mid_threshold;
		logic [WEIGHT_W-1:0] weight_high_band;
		logic [WEIGHT_W-1:0] weight_mid_band;
		logic [WEIGHT_W-1:0] weight_low_band;
	} sfs_cfg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} sfs_q_status_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_DIV,
		BK_MUL,
		BK_REC,
		BK_FIX
	} sfs_back_state_t;

endpackage
`default_nettype wire

[design/sfs_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Segment fragmentation scorer front end
// Counts invalid blocks and invalid runs and queues one record per segment.
// ----------------------------------------------------------------------------
module sfs_front
	import sfs_pkg::*;
#(
	parameter int MAX_BLOCKS = 512,
	parameter int CNT_W      = $clog2(MAX_BLOCKS + 1),
	parameter int REC_W      = 2 * FIELD_W + 2 * CNT_W
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire sfs_in_t          in_data,
	input  wire sfs_q_status_t    q_status,
	output logic                  push,
	output logic [REC_W-1:0]      push_data
);

	localparam logic [CNT_W-1:0] SAT = CNT_W'(MAX_BLOCKS);

	logic [CNT_W-1:0] inv_q;
	logic [CNT_W-1:0] run_q;
	logic             prev_inv_q;
	logic [CNT_W-1:0] inv_next;
	logic [CNT_W-1:0] run_next;
	logic             accept;

	assign in_stall = q_status.full;
	assign accept   = in_valid && !q_status.full;

	always_comb begin
		inv_next = inv_q;
		run_next = run_q;
		if (!in_data.block_valid) begin
			if (inv_q < SAT) begin
				inv_next = inv_q + 1'b1;
			end
			if (!prev_inv_q && (run_q < SAT)) begin
				run_next = run_q + 1'b1;
			end
		end
	end

	assign push      = accept && in_data.last_block;
	assign push_data = {in_data.segment_id, in_data.base_cost, inv_next, run_next};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_q      <= '0;
			run_q      <= '0;
			prev_inv_q <= 1'b0;
		end else if (accept) begin
			if (in_data.last_block) begin
				inv_q      <= '0;
				run_q      <= '0;
				prev_inv_q <= 1'b0;
			end else begin
				inv_q      <= inv_next;
				run_q      <= run_next;
				prev_inv_q <= !in_data.block_valid;
			end
		end
	end

endmodule
`default_nettype wire

[design/sfs_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Segment fragmentation scorer record queue
// Short register queue that parts the front end from the scoring back end.
// ----------------------------------------------------------------------------
module sfs_fifo
	import sfs_pkg::*;
#(
	parameter int WIDTH = 52,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rd_data,
	output sfs_q_status_t         status
);

	`include "segment_fragmentation_scorer_top_macros.svh"

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign status.empty = (count_q == '0);
	assign rd_data      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`SFS_ASSERT_NEVER(a_no_push_full, push && status.full)
	`SFS_ASSERT_NEVER(a_no_pop_empty, pop && status.empty)
	`SFS_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CNT_W'(DEPTH))

endmodule
`default_nettype wire

[design/sfs_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Segment fragmentation scorer back end
// Divides for the score, picks the band weight and scales the GC cost.
// ----------------------------------------------------------------------------
module sfs_back
	import sfs_pkg::*;
#(
	parameter int CNT_W = 10,
	parameter int REC_W = 2 * FIELD_W + 2 * CNT_W
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire sfs_cfg_t         cfg,
	input  wire sfs_q_status_t    q_status,
	output logic                  pop,
	input  wire logic [REC_W-1:0] rd_data,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output sfs_out_t              out_data
);

	`include "segment_fragmentation_scorer_top_macros.svh"

	localparam int NUM_W    = CNT_W + SCORE_W;
	localparam int FIX_W    = COST_W + SCORE_W;
	localparam int BIT_TOP  = SCORE_W - 1;

	sfs_back_state_t state_q;
	sfs_back_state_t state_d;
	logic            out_load;

	logic [FIELD_W-1:0]  seg_q;
	logic [FIELD_W-1:0]  base_q;
	logic [CNT_W-1:0]    inv_q;
	logic [CNT_W-1:0]    run_q;
	logic [NUM_W-1:0]    rem_q;
	logic [2:0]          bit_q;
	logic [SCORE_W-1:0]  quot_q;
	logic [SCORE_W-1:0]  score_q;
	logic                hfrag_q;
	logic [PROD_W-1:0]   prod_q;
	logic [COST_W-1:0]   est_q;
	logic                out_valid_q;
	sfs_out_t            out_data_q;

	logic [CNT_W-1:0]    rd_inv;
	logic [CNT_W-1:0]    rd_run;
	logic [NUM_W-1:0]    numer;
	logic [NUM_W-1:0]    trial;
	logic                ge;
	logic [SCORE_W-1:0]  score;
	logic [WEIGHT_W-1:0] weight;
	logic [2*PROD_W-1:0] recip_prod;
	logic [FIX_W-1:0]    est_x100;
	logic [FIX_W-1:0]    fix_rem;
	logic [COST_W-1:0]   cost;

	assign rd_inv = rd_data[2*CNT_W-1:CNT_W];
	assign rd_run = rd_data[CNT_W-1:0];
	assign numer  = NUM_W'(rd_run) * NUM_W'(SCORE_SCALE);
	assign trial  = NUM_W'(inv_q) << bit_q;
	assign ge     = (rem_q >= trial);

	always_comb begin
		score = (inv_q == '0) ? '0 : quot_q;
		priority if (score > cfg.band_high_threshold) begin
			weight = cfg.weight_high_band;
		end else if (score > cfg.band_mid_threshold) begin
			weight = cfg.weight_mid_band;
		end else begin
			weight = cfg.weight_low_band;
		end
	end

	assign recip_prod = prod_q * RECIP_MULT;
	assign est_x100   = FIX_W'(est_q) * FIX_W'(SCORE_SCALE);
	assign fix_rem    = FIX_W'(prod_q) - est_x100;
	assign cost       = (fix_rem >= FIX_W'(SCORE_SCALE)) ? est_q + 1'b1 : est_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_status.empty) begin
					pop     = 1'b1;
					state_d = BK_DIV;
				end
			end
			BK_DIV: begin
				if (bit_q == '0) begin
					state_d = BK_MUL;
				end
			end
			BK_MUL: begin
				state_d = BK_REC;
			end
			BK_REC: begin
				state_d = BK_FIX;
			end
			BK_FIX: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			seg_q  <= rd_data[REC_W-1 -: FIELD_W];
			base_q <= rd_data[REC_W-FIELD_W-1 -: FIELD_W];
			inv_q  <= rd_inv;
			run_q  <= rd_run;
			rem_q  <= numer;
			bit_q  <= 3'(BIT_TOP);
			quot_q <= '0;
		end
		if (state_q == BK_DIV) begin
			quot_q <= {quot_q[SCORE_W-2:0], ge};
			if (ge) begin
				rem_q <= rem_q - trial;
			end
			bit_q <= bit_q - 1'b1;
		end
		if (state_q == BK_MUL) begin
			score_q <= score;
			hfrag_q <= (score > cfg.high_frag_threshold);
			prod_q  <= PROD_W'(base_q) * PROD_W'(weight);
		end
		if (state_q == BK_REC) begin
			est_q <= recip_prod[RECIP_SHIFT +: COST_W];
		end
		if (out_load) begin
			out_data_q.result_segment <= seg_q;
			out_data_q.invalid_count  <= COUNT_W'(inv_q);
			out_data_q.run_count      <= COUNT_W'(run_q);
			out_data_q.score_pct      <= score_q;
			out_data_q.high_frag      <= hfrag_q;
			out_data_q.weighted_cost  <= cost;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`SFS_ASSERT_IMP(a_div_bit_range, state_q == BK_DIV, bit_q <= 3'(BIT_TOP))
	`SFS_ASSERT_IMP(a_score_range, state_q == BK_MUL, score <= SCORE_SCALE)
	`SFS_ASSERT_IMP(a_recip_close, state_q == BK_FIX, fix_rem < FIX_W'(2 * SCORE_SCALE))

endmodule
`default_nettype wire

[design/segment_fragmentation_scorer_top.sv]
// Throughput: one block transaction per cycle while the record queue is not full. The back
// end scores one segment at a time and pops the next record only after the previous one
// has passed the 7-step score divider and the 3-step cost scaling.
// Input stalls only while the two-entry record queue is full.
// Reset clears tallies, queue and output valid and loads default register values.
`default_nettype none
// ----------------------------------------------------------------------------
// Segment fragmentation scorer top level
// Configuration registers, front end, record queue and scoring back end.
// ----------------------------------------------------------------------------
module segment_fragmentation_scorer_top
	import sfs_pkg::*;
#(
	parameter int MAX_BLOCKS = 512
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire sfs_in_t               in_data,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output sfs_out_t                   out_data,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
	localparam int REC_W = 2 * FIELD_W + 2 * CNT_W;

	sfs_cfg_t         cfg_q;
	sfs_q_status_t    q_status;
	logic             push;
	logic [REC_W-1:0] push_data;
	logic             pop;
	logic [REC_W-1:0] rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.high_frag_threshold <= HIGH_FRAG_THR_RST;
			cfg_q.band_high_threshold <= BAND_HIGH_THR_RST;
			cfg_q.band_mid_threshold  <= BAND_MID_THR_RST;
			cfg_q.weight_high_band    <= WEIGHT_HIGH_RST;
			cfg_q.weight_mid_band     <= WEIGHT_MID_RST;
			cfg_q.weight_low_band     <= WEIGHT_LOW_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_HIGH_FRAG_THR: cfg_q.high_frag_threshold <= cfg_data[THR_W-1:0];
				CFG_BAND_HIGH_THR: cfg_q.band_high_threshold <= cfg_data[THR_W-1:0];
				CFG_BAND_MID_THR:  cfg_q.band_mid_threshold  <= cfg_data[THR_W-1:0];
				CFG_WEIGHT_HIGH:   cfg_q.weight_high_band    <= cfg_data;
				CFG_WEIGHT_MID:    cfg_q.weight_mid_band     <= cfg_data;
				CFG_WEIGHT_LOW:    cfg_q.weight_low_band     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	sfs_front #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.CNT_W      (CNT_W),
		.REC_W      (REC_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.q_status  (q_status),
		.push      (push),
		.push_data (push_data)
	);

	sfs_fifo #(
		.WIDTH (REC_W),
		.DEPTH (2)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.rd_data   (rd_data),
		.status    (q_status)
	);

	sfs_back #(
		.CNT_W (CNT_W),
		.REC_W (REC_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_status  (q_status),
		.pop       (pop),
		.rd_data   (rd_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire
